FILE: rtl/vector3_alu_defines.svh
// Assertion helpers for the vector ALU.
`ifndef VECTOR3_ALU_DEFINES_SVH
`define VECTOR3_ALU_DEFINES_SVH

// Check that cons holds in every cycle where ante holds.
`define V3A_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond never holds.
`define V3A_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/v3a_pkg.sv
`default_nettype none

package v3a_pkg;

  typedef enum logic [3:0] {
    KIND_ADD   = 4'd0,
    KIND_SUB   = 4'd1,
    KIND_NEG   = 4'd2,
    KIND_CROSS = 4'd3,
    KIND_DOT   = 4'd4,
    KIND_SCALE = 4'd5,
    KIND_DIV   = 4'd6,
    KIND_LEN   = 4'd7,
    KIND_NORM  = 4'd8,
    KIND_EQUAL = 4'd9
  } kind_e;

  // Width of the intermediate sums before saturation.
  localparam int WideW = 66;
  localparam logic signed [WideW-1:0] S32MaxW = 66'sd2147483647;
  localparam logic signed [WideW-1:0] S32MinW = -66'sd2147483648;
  localparam logic [31:0] S32Max = 32'h7fff_ffff;
  localparam logic [31:0] S32Min = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] val;
    logic        ov;
  } sat_t;

  typedef struct packed {
    logic [31:0] r;
    logic        ov;
    logic        eq;
  } lane_res_t;

  typedef struct packed {
    kind_e           kind;
    logic [2:0][31:0] a;
    logic [31:0]     s;
    logic [2:0][31:0] rv;
    logic [31:0]     sc;
    logic            eq;
    logic            ov;
  } pipe_t;

  typedef struct packed {
    pipe_t       side;
    logic [32:0] len;
  } pipe2_t;

  // Clamp a wide signed value to the 32-bit range.
  function automatic sat_t sat32(input logic signed [WideW-1:0] v);
    sat_t res;
    if (v > S32MaxW) begin
      res.val = S32Max;
      res.ov  = 1'b1;
    end else if (v < S32MinW) begin
      res.val = S32Min;
      res.ov  = 1'b1;
    end else begin
      res.val = v[31:0];
      res.ov  = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/v3a_lane.sv
`default_nettype none

module v3a_lane import v3a_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  kind_e              kind_i,
  input  logic signed [31:0] ai_i,
  input  logic signed [31:0] aj_i,
  input  logic signed [31:0] ak_i,
  input  logic signed [31:0] bi_i,
  input  logic signed [31:0] bj_i,
  input  logic signed [31:0] bk_i,
  input  logic signed [31:0] s_i,
  output logic signed [63:0] m0_o,
  output lane_res_t          res_o
);

  localparam logic signed [WideW-1:0] Half = WideW'(1) <<< (FRAC_BITS - 1);

  logic signed [31:0] op0a, op0b, op1a, op1b;
  logic signed [32:0] ai_x, bi_x, sum_add, sum_sub, neg_a;
  sat_t               simple_d, simple_q, prod;
  logic signed [63:0] m0_q, m1_q;
  logic               eq_q;
  kind_e              kind_q;
  logic signed [WideW-1:0] diff, shifted;
  lane_res_t          res_d, res_q;

  // Pick multiplier operands for this element
  always_comb begin
    op0a = '0;
    op0b = '0;
    op1a = '0;
    op1b = '0;
    case (kind_i) inside
      KIND_CROSS: begin
        op0a = aj_i;
        op0b = bk_i;
        op1a = ak_i;
        op1b = bj_i;
      end
      KIND_DOT: begin
        op0a = ai_i;
        op0b = bi_i;
      end
      KIND_SCALE: begin
        op0a = ai_i;
        op0b = s_i;
      end
      KIND_LEN, KIND_NORM: begin
        op0a = ai_i;
        op0b = ai_i;
      end
      default: ;
    endcase
  end

  // Add, subtract and negate with saturation
  always_comb begin
    ai_x    = 33'(ai_i);
    bi_x    = 33'(bi_i);
    sum_add = ai_x + bi_x;
    sum_sub = ai_x - bi_x;
    neg_a   = -ai_x;
    case (kind_i) inside
      KIND_ADD: simple_d = sat32(WideW'(sum_add));
      KIND_SUB: simple_d = sat32(WideW'(sum_sub));
      KIND_NEG: simple_d = sat32(WideW'(neg_a));
      default:  simple_d = '0;
    endcase
  end

  // Multiply stage
  always_ff @(posedge clk_i) begin
    m0_q     <= op0a * op0b;
    m1_q     <= op1a * op1b;
    simple_q <= simple_d;
    eq_q     <= (ai_i == bi_i);
    kind_q   <= kind_i;
  end

  // Combine products, round half up, clamp
  always_comb begin
    diff    = WideW'(m0_q) - WideW'(m1_q) + Half;
    shifted = diff >>> FRAC_BITS;
    prod    = sat32(shifted);
    res_d   = '0;
    res_d.eq = eq_q;
    case (kind_q) inside
      KIND_ADD, KIND_SUB, KIND_NEG: begin
        res_d.r  = simple_q.val;
        res_d.ov = simple_q.ov;
      end
      KIND_CROSS, KIND_SCALE: begin
        res_d.r  = prod.val;
        res_d.ov = prod.ov;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m0_o  = m0_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/v3a_sqrt.sv
`default_nettype none

module v3a_sqrt (
  input  logic        clk_i,
  input  logic [63:0] sum_i,
  output logic [32:0] len_o
);

  localparam int Steps = 32;

  logic [63:0] rest_q [Steps];
  logic [31:0] root_q [Steps];
  logic [33:0] rem_q  [Steps];
  logic [32:0] len_q;

  // One root bit per stage
  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [63:0] rest_p;
    logic [31:0] root_p;
    logic [33:0] rem_p;
    logic [35:0] part, trial;

    if (k == 0) begin : g_first
      assign rest_p = sum_i;
      assign root_p = '0;
      assign rem_p  = '0;
    end else begin : g_next
      assign rest_p = rest_q[k-1];
      assign root_p = root_q[k-1];
      assign rem_p  = rem_q[k-1];
    end

    assign part  = {rem_p, rest_p[63:62]};
    assign trial = {2'b00, root_p, 2'b01};

    always_ff @(posedge clk_i) begin
      rest_q[k] <= {rest_p[61:0], 2'b00};
      if (part >= trial) begin
        rem_q[k]  <= 34'(part - trial);
        root_q[k] <= {root_p[30:0], 1'b1};
      end else begin
        rem_q[k]  <= part[33:0];
        root_q[k] <= {root_p[30:0], 1'b0};
      end
    end
  end

  // Round to nearest: bump when remainder exceeds root
  always_ff @(posedge clk_i) begin
    len_q <= {1'b0, root_q[Steps-1]}
           + 33'(rem_q[Steps-1] > {2'b00, root_q[Steps-1]});
  end

  assign len_o = len_q;

endmodule

`default_nettype wire

FILE: rtl/v3a_div.sv
`default_nettype none

module v3a_div #(
  parameter int QW = 49
) (
  input  logic          clk_i,
  input  logic [QW-1:0] num_i,
  input  logic [32:0]   den_i,
  output logic [QW-1:0] quo_o
);

  localparam int RW = 34;

  logic [RW-1:0] rem_q [QW];
  logic [QW-1:0] dq_q  [QW];
  logic [32:0]   den_q [QW];

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW-1:0] rem_p, part;
    logic [QW-1:0] dq_p;
    logic [32:0]   den_p;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign dq_p  = num_i;
      assign den_p = den_i;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign dq_p  = dq_q[k-1];
      assign den_p = den_q[k-1];
    end

    assign part = {rem_p[RW-2:0], dq_p[QW-1]};
    assign ge   = (part >= {1'b0, den_p});

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? (part - {1'b0, den_p}) : part;
      dq_q[k]  <= {dq_p[QW-2:0], ge};
      den_q[k] <= den_p;
    end
  end

  assign quo_o = dq_q[QW-1];

endmodule

`default_nettype wire

FILE: rtl/vector3_alu.sv
`default_nettype none
// Three-component vector ALU, signed fixed point with FRAC_BITS fraction bits.
// Command port: an operation is taken on a rising edge with start_i high and
// busy_o low. busy_o is always low, so one operation can enter every cycle.
// Each operation yields exactly one result, shown for one cycle with done_o
// high; the receiver must take it then, as it cannot hold results off.
// Every kind passes through the whole pipeline, so results leave in the order
// operations entered.
// The pipeline holds: an input register, a multiply stage in three element
// lanes, a round stage and lane merge, a 32-stage square root, a round stage,
// and a three-lane restoring divider of 33 + FRAC_BITS stages, one quotient
// bit per stage; the divider depth sets the latency.
// Throughput is one operation per cycle.
// Reset clears all valid bits, so no done_o appears until an operation that
// entered after reset has passed through.
`include "vector3_alu_defines.svh"

module vector3_alu import v3a_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [3:0]         kind_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] az_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  input  logic signed [31:0] bz_i,
  input  logic signed [31:0] scale_i,
  output logic               done_o,
  output logic signed [31:0] rx_o,
  output logic signed [31:0] ry_o,
  output logic signed [31:0] rz_o,
  output logic signed [31:0] scalar_o,
  output logic               equal_o,
  output logic               overflow_o,
  output logic               div_zero_o
);

  localparam int SQ = 33;
  localparam int QW = 33 + FRAC_BITS;
  localparam logic signed [WideW-1:0] Half = WideW'(1) <<< (FRAC_BITS - 1);

  logic               accept;
  logic               valid_a_q, valid_b_q, valid_c_q, valid_d_q;
  logic [SQ-1:0]      vld1_q;
  logic [QW-1:0]      vld2_q;
  logic               done_q;

  kind_e              kind_a_q, kind_b_q, kind_c_q;
  logic signed [31:0] a_a_q [3];
  logic signed [31:0] b_a_q [3];
  logic signed [31:0] s_a_q, s_b_q, s_c_q;
  logic [31:0]        a_b_q [3];
  logic [31:0]        a_c_q [3];
  logic signed [63:0] m0 [3];
  lane_res_t          lane_res [3];
  logic signed [WideW-1:0] sum_c_q, dot_w;
  sat_t               dot_s;

  pipe_t              side_d, side_d_q;
  logic [63:0]        sum_d_q;
  pipe_t              line1_q [SQ];
  pipe2_t             line2_q [QW];
  pipe_t              t1;
  pipe2_t             t2;
  logic [32:0]        len_w;
  logic [QW-1:0]      num [3];
  logic [32:0]        den;
  logic [31:0]        s_mag;
  logic [QW-1:0]      quo [3];

  pipe_t              fin;
  logic               dz_d;
  sat_t               lsat;
  sat_t               qsat [3];
  logic signed [WideW-1:0] qval [3];

  logic [31:0]        rx_q, ry_q, rz_q, sc_q;
  logic               eq_q, ov_q, dz_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Valid bits along the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
      vld1_q    <= '0;
      vld2_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      valid_a_q <= accept;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
      valid_d_q <= valid_c_q;
      vld1_q    <= {vld1_q[SQ-2:0], valid_d_q};
      vld2_q    <= {vld2_q[QW-2:0], vld1_q[SQ-1]};
      done_q    <= vld2_q[QW-1];
    end
  end

  // Capture the beat
  always_ff @(posedge clk_i) begin
    kind_a_q <= kind_e'(kind_i);
    a_a_q[0] <= ax_i;
    a_a_q[1] <= ay_i;
    a_a_q[2] <= az_i;
    b_a_q[0] <= bx_i;
    b_a_q[1] <= by_i;
    b_a_q[2] <= bz_i;
    s_a_q    <= scale_i;
  end

  // Element lanes
  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i  (clk_i),
      .kind_i (kind_a_q),
      .ai_i   (a_a_q[i]),
      .aj_i   (a_a_q[J]),
      .ak_i   (a_a_q[K]),
      .bi_i   (b_a_q[i]),
      .bj_i   (b_a_q[J]),
      .bk_i   (b_a_q[K]),
      .s_i    (s_a_q),
      .m0_o   (m0[i]),
      .res_o  (lane_res[i])
    );
  end

  // Carry operands alongside the lanes; merge lane products
  always_ff @(posedge clk_i) begin
    kind_b_q <= kind_a_q;
    s_b_q    <= s_a_q;
    kind_c_q <= kind_b_q;
    s_c_q    <= s_b_q;
    for (int i = 0; i < 3; i++) begin
      a_b_q[i] <= a_a_q[i];
      a_c_q[i] <= a_b_q[i];
    end
    sum_c_q <= WideW'(m0[0]) + WideW'(m0[1]) + WideW'(m0[2]);
  end

  // Round the dot product and assemble the sideband
  always_comb begin
    dot_w       = (sum_c_q + Half) >>> FRAC_BITS;
    dot_s       = sat32(dot_w);
    side_d      = '0;
    side_d.kind = kind_c_q;
    side_d.s    = s_c_q;
    for (int i = 0; i < 3; i++) begin
      side_d.a[i]  = a_c_q[i];
      side_d.rv[i] = lane_res[i].r;
    end
    side_d.eq = (kind_c_q == KIND_EQUAL) && lane_res[0].eq && lane_res[1].eq
              && lane_res[2].eq;
    side_d.ov = lane_res[0].ov | lane_res[1].ov | lane_res[2].ov;
    if (kind_c_q == KIND_DOT) begin
      side_d.sc = dot_s.val;
      side_d.ov = dot_s.ov;
    end
  end

  always_ff @(posedge clk_i) begin
    side_d_q <= side_d;
    sum_d_q  <= sum_c_q[63:0];
  end

  // Length of a
  v3a_sqrt u_sqrt (
    .clk_i (clk_i),
    .sum_i (sum_d_q),
    .len_o (len_w)
  );

  // Hold the sideband while the root forms
  always_ff @(posedge clk_i) begin
    line1_q[0] <= side_d_q;
    for (int k = 1; k < SQ; k++) begin
      line1_q[k] <= line1_q[k-1];
    end
  end

  assign t1    = line1_q[SQ-1];
  assign s_mag = t1.s[31] ? (~t1.s + 32'd1) : t1.s;
  assign den   = (t1.kind == KIND_DIV) ? {1'b0, s_mag} : len_w;

  // Dividers, one per element
  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [31:0] mag;
    assign mag    = t1.a[i][31] ? (~t1.a[i] + 32'd1) : t1.a[i];
    assign num[i] = {1'b0, mag, {FRAC_BITS{1'b0}}} + QW'(den[32:1]);
    v3a_div #(.QW(QW)) u_div (
      .clk_i (clk_i),
      .num_i (num[i]),
      .den_i (den),
      .quo_o (quo[i])
    );
  end

  // Hold the sideband and length while the quotients form
  always_ff @(posedge clk_i) begin
    line2_q[0] <= '{side: t1, len: len_w};
    for (int k = 1; k < QW; k++) begin
      line2_q[k] <= line2_q[k-1];
    end
  end

  assign t2 = line2_q[QW-1];

  // Final select per kind
  always_comb begin
    fin  = t2.side;
    dz_d = 1'b0;
    lsat = sat32({{(WideW-33){1'b0}}, t2.len});
    for (int i = 0; i < 3; i++) begin
      qval[i] = {{(WideW-QW){1'b0}}, quo[i]};
      if (t2.side.a[i][31] ^ ((t2.side.kind == KIND_DIV) && t2.side.s[31])) begin
        qval[i] = -qval[i];
      end
      qsat[i] = sat32(qval[i]);
    end
    case (t2.side.kind) inside
      KIND_DIV: begin
        if (t2.side.s == '0) begin
          dz_d = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (t2.side.a[i][31]) begin
              fin.rv[i] = S32Min;
            end else if (t2.side.a[i] != '0) begin
              fin.rv[i] = S32Max;
            end else begin
              fin.rv[i] = '0;
            end
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            fin.rv[i] = qsat[i].val;
          end
          fin.ov = qsat[0].ov | qsat[1].ov | qsat[2].ov;
        end
      end
      KIND_NORM: begin
        if (t2.len == '0) begin
          fin.rv = t2.side.a;
        end else begin
          for (int i = 0; i < 3; i++) begin
            fin.rv[i] = qsat[i].val;
          end
          fin.ov = qsat[0].ov | qsat[1].ov | qsat[2].ov;
        end
      end
      KIND_LEN: begin
        fin.sc = lsat.val;
        fin.ov = lsat.ov;
      end
      default: ;
    endcase
  end

  // Output beat
  always_ff @(posedge clk_i) begin
    rx_q <= fin.rv[0];
    ry_q <= fin.rv[1];
    rz_q <= fin.rv[2];
    sc_q <= fin.sc;
    eq_q <= fin.eq;
    ov_q <= fin.ov;
    dz_q <= dz_d;
  end

  assign done_o     = done_q;
  assign rx_o       = rx_q;
  assign ry_o       = ry_q;
  assign rz_o       = rz_q;
  assign scalar_o   = sc_q;
  assign equal_o    = eq_q;
  assign overflow_o = ov_q;
  assign div_zero_o = dz_q;

  `V3A_ASSERT_IMP(a_dz_clean, clk_i, rst_ni, done_o && div_zero_o, !overflow_o && !equal_o && scalar_o == 32'sd0, "zero divisor beat carries other flags")
  `V3A_ASSERT_IMP(a_eq_only, clk_i, rst_ni, done_o && equal_o, rx_o == 32'sd0 && ry_o == 32'sd0 && rz_o == 32'sd0 && !overflow_o && !div_zero_o, "equal beat carries data")
  `V3A_ASSERT_NEVER(a_len_range, clk_i, rst_ni, vld1_q[SQ-1] && (len_w > 33'h1_0000_0000), "rounded root out of range")

endmodule

`default_nettype wire

FILE: test/vector3_alu_tb.sv
`timescale 1ns / 100ps

module vector3_alu_tb;
  import v3a_pkg::*;

  localparam int FracBits = 16;
  localparam int Latency = 70 + FracBits;

  typedef struct {
    logic [31:0] rx, ry, rz, scalar;
    logic        equal, overflow, div_zero;
  } vec_res_t;

  typedef struct {
    logic [3:0]  kind;
    logic [31:0] ax, ay, az, bx, by, bz, scale;
  } vec_op_t;

  // Clamp a wide value to 32 bits, flag saturation
  function automatic logic [31:0] clamp_s32(input longint v, inout logic ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Exact sum of products, shifted down by the fraction, rounded half up
  function automatic longint fix_round(input logic signed [95:0] acc);
    logic signed [95:0] t;
    t = (acc + (96'sd1 <<< (FracBits - 1))) >>> FracBits;
    if (t > 96'sd4611686018427387903) return 64'sh3fff_ffff_ffff_ffff;
    if (t < -96'sd4611686018427387904) return -64'sh4000_0000_0000_0000;
    return longint'(t);
  endfunction

  // a * 2^F / d, rounded half away from zero
  function automatic longint fix_div(input longint a, input logic [63:0] den,
                                     input bit neg);
    logic [95:0] mag, q;
    mag = (a < 0) ? 96'(-a) : 96'(a);
    q = ((mag << FracBits) + 96'(den / 2)) / 96'(den);
    if (q > 96'h3fff_ffff_ffff_ffff) q = 96'h3fff_ffff_ffff_ffff;
    return ((a < 0) != neg) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [63:0] root_round(input logic [63:0] s);
    logic [63:0] res, bitv, rem;
    res = 0;
    bitv = 64'd1 << 62;
    rem = s;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (rem > res) res++;
    return res;
  endfunction

  function automatic vec_res_t vector_op(input vec_op_t op);
    vec_res_t o;
    longint a[3], b[3], s, len;
    logic signed [95:0] acc;
    logic [63:0] sum, d;
    int j, k;
    o = '{default: '0};
    a[0] = longint'(signed'(op.ax)); a[1] = longint'(signed'(op.ay));
    a[2] = longint'(signed'(op.az));
    b[0] = longint'(signed'(op.bx)); b[1] = longint'(signed'(op.by));
    b[2] = longint'(signed'(op.bz));
    s = longint'(signed'(op.scale));
    case (op.kind)
      KIND_ADD, KIND_SUB, KIND_NEG: begin
        for (int i = 0; i < 3; i++) begin
          logic [31:0] v;
          if (op.kind == KIND_ADD) v = clamp_s32(a[i] + b[i], o.overflow);
          else if (op.kind == KIND_SUB) v = clamp_s32(a[i] - b[i], o.overflow);
          else v = clamp_s32(-a[i], o.overflow);
          if (i == 0) o.rx = v; else if (i == 1) o.ry = v; else o.rz = v;
        end
      end
      KIND_CROSS, KIND_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          logic [31:0] v;
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          if (op.kind == KIND_CROSS)
            acc = 96'(a[j]) * 96'(b[k]) - 96'(a[k]) * 96'(b[j]);
          else
            acc = 96'(a[i]) * 96'(s);
          v = clamp_s32(fix_round(acc), o.overflow);
          if (i == 0) o.rx = v; else if (i == 1) o.ry = v; else o.rz = v;
        end
      end
      KIND_DOT: begin
        acc = 96'(a[0]) * 96'(b[0]) + 96'(a[1]) * 96'(b[1])
            + 96'(a[2]) * 96'(b[2]);
        o.scalar = clamp_s32(fix_round(acc), o.overflow);
      end
      KIND_DIV: begin
        logic [31:0] rr[3];
        if (s == 0) begin
          o.div_zero = 1'b1;
          foreach (rr[i])
            rr[i] = (a[i] > 0) ? 32'h7fff_ffff : (a[i] < 0) ? 32'h8000_0000 : 32'h0;
        end else begin
          d = (s < 0) ? -s : s;
          foreach (rr[i]) rr[i] = clamp_s32(fix_div(a[i], d, s < 0), o.overflow);
        end
        o.rx = rr[0]; o.ry = rr[1]; o.rz = rr[2];
      end
      KIND_LEN, KIND_NORM: begin
        logic [31:0] rr[3];
        sum = 0;
        foreach (a[i]) sum += a[i] * a[i];
        len = root_round(sum);
        if (op.kind == KIND_LEN) begin
          o.scalar = clamp_s32(len, o.overflow);
        end else begin
          foreach (rr[i])
            rr[i] = (len == 0) ? a[i][31:0]
                  : clamp_s32(fix_div(a[i], len, 1'b0), o.overflow);
          o.rx = rr[0]; o.ry = rr[1]; o.rz = rr[2];
        end
      end
      KIND_EQUAL: o.equal = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
      default: ;
    endcase
    return o;
  endfunction

  // Holds expected results in issue order and compares returned beats
  class vec_scoreboard;
    vec_res_t pending[$];
    int       errors;

    function void note_op(vec_op_t op);
      pending.push_back(vector_op(op));
    endfunction

    function void check_result(vec_res_t got);
      vec_res_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.rx !== e.rx) begin $error("rx exp %h got %h", e.rx, got.rx); errors++; end
      if (got.ry !== e.ry) begin $error("ry exp %h got %h", e.ry, got.ry); errors++; end
      if (got.rz !== e.rz) begin $error("rz exp %h got %h", e.rz, got.rz); errors++; end
      if (got.scalar !== e.scalar) begin
        $error("scalar exp %h got %h", e.scalar, got.scalar); errors++;
      end
      if (got.equal !== e.equal) begin
        $error("equal exp %b got %b", e.equal, got.equal); errors++;
      end
      if (got.overflow !== e.overflow) begin
        $error("overflow exp %b got %b", e.overflow, got.overflow); errors++;
      end
      if (got.div_zero !== e.div_zero) begin
        $error("div_zero exp %b got %b", e.div_zero, got.div_zero); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [3:0]  kind_i = '0;
  logic [31:0] ax_i = '0, ay_i = '0, az_i = '0, bx_i = '0, by_i = '0, bz_i = '0;
  logic [31:0] scale_i = '0;
  logic        busy_o, done_o, equal_o, overflow_o, div_zero_o;
  logic [31:0] rx_o, ry_o, rz_o, scalar_o;

  vec_scoreboard sb = new();
  int idle_pct;

  vector3_alu #(.FRAC_BITS(FracBits)) u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Note accepted beats and check returned ones at each edge
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      sb.note_op('{kind_i, ax_i, ay_i, az_i, bx_i, by_i, bz_i, scale_i});
    if (rst_ni && done_o)
      sb.check_result('{rx_o, ry_o, rz_o, scalar_o, equal_o, overflow_o, div_zero_o});
  end

  // Drive one beat, idling at random first; leaves start high
  task automatic send_op(input vec_op_t op);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    kind_i <= op.kind;
    {ax_i, ay_i, az_i} <= {op.ax, op.ay, op.az};
    {bx_i, by_i, bz_i} <= {op.bx, op.by, op.bz};
    scale_i <= op.scale;
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic logic [31:0] pick_val();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
      4: return $urandom_range(0, 32'hff_ffff) - 32'h80_0000;
      5: return 32'h0001_0000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    #100000;
    $display("[vector3_alu] ERROR");
    $finish;
  end

  initial begin
    vec_op_t op;
    logic [31:0] ext[4];
    ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff};
    idle_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every kind at the extremes, plus the named corner cases
    for (int kd = 0; kd < 16; kd++) begin
      op = '{4'(kd), ext[kd % 4], ext[(kd + 1) % 4], ext[(kd + 2) % 4],
             ext[(kd + 3) % 4], ext[kd % 4], ext[(kd + 1) % 4], ext[(kd + 2) % 4]};
      send_op(op);
    end
    send_op('{KIND_DIV, 32'h10000, 32'hffff0000, 0, 0, 0, 0, 0});
    send_op('{KIND_NORM, 0, 0, 0, 0, 0, 0, 0});
    send_op('{KIND_NEG, 32'h8000_0000, 5, 0, 0, 0, 0, 0});
    send_op('{KIND_EQUAL, 7, 8, 9, 7, 8, 9, 0});
    send_op('{KIND_LEN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0});
    send_op('{KIND_SCALE, 32'h8000, 32'hffff_8000, 3, 0, 0, 0, 32'h8000});

    // Random phases: sender idles a third, then most of the time, then never
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 33 : (ph == 1) ? 64 : 0;
      repeat (460) begin
        op.kind = ($urandom_range(19) == 0) ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(9));
        op.ax = pick_val(); op.ay = pick_val(); op.az = pick_val();
        if (op.kind == KIND_EQUAL && $urandom_range(1)) begin
          {op.bx, op.by, op.bz} = {op.ax, op.ay, op.az};
          if ($urandom_range(1)) op.by ^= 32'(1) << $urandom_range(31);
        end else begin
          op.bx = pick_val(); op.by = pick_val(); op.bz = pick_val();
        end
        op.scale = pick_val();
        send_op(op);
      end
    end
    start_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (sb.errors == 0) $display("[vector3_alu] OK");
    else $display("[vector3_alu] ERROR");
    $finish;
  end
endmodule
